/* rtl/core/sha256_pkg.sv */
// SHA-256 package: round constants, initial hash values, state codes and helper functions.
// Used by sha256_message_hasher. It has no dependencies.
`timescale 1ns / 1ps
package sha256_pkg;
   localparam int unsigned BlkBytes = 64;

   typedef enum logic [6:0] {
      ST_COLLECT = 7'b0000001,
      ST_PAD     = 7'b0000010,
      ST_LOAD    = 7'b0000100,
      ST_ROUND   = 7'b0001000,
      ST_ADD     = 7'b0010000,
      ST_EMIT    = 7'b0100000,
      ST_WAIT    = 7'b1000000
   } state_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

/* rtl/core/sha256_ram.sv */
// Generic simple dual-port synchronous RAM with one write port and a registered read.
// It has no dependencies.
`timescale 1ns / 1ps
module sha256_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/core/sha256_message_hasher.sv */
// SHA-256 hasher top level: byte collection, padding, round engine and digest output.
// Depends on sha256_pkg and sha256_ram.
`timescale 1ns / 1ps
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | data_byte, byte_present, final_item
//  rsp     | out       | rsp_valid/rsp_ready   | digest_word, word_number, last_word
//
// A word that neither fills a block nor is final leaves the hasher collecting. The
// 64th byte of a block starts a compression: a load pass through the byte RAM,
// 64 rounds of the single round unit and an add into the hash words.
// A final word writes its padding one byte a cycle, runs one or two compressions
// and then offers eight digest words; req_ready stays low until the last is taken
// and while the hash words are set back after it. Reset is synchronous and needs
// no clearing pass; the byte RAM is always written before it is read.
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_final_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);
   import sha256_pkg::*;

   state_type   state_ff, state_in;
   logic [6:0]  fill_ff, fill_in;       // bytes held, or pad write pointer
   logic [63:0] bitlen_ff, bitlen_in;
   logic        final_ff, final_in;     // final padding in progress
   logic        lenpass_ff, lenpass_in; // this compression holds the length
   logic        marked_ff, marked_in;   // the 0x80 pad byte has been written
   logic [6:0]  cnt_ff, cnt_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [2:0]  onum_ff, onum_in;

   logic        ram_we;
   logic [5:0]  ram_wa, ram_ra;
   logic [7:0]  ram_wd, ram_rd;

   sha256_ram #(.Width(8), .Depth(BlkBytes)) u_blk (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   logic [31:0] s0, s1, wnext, t1, t2, e, a, kw;

   assign req_ready = (state_ff == ST_COLLECT);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_digest_word = h_ff[onum_ff];
   assign rsp_word_number = onum_ff;
   assign rsp_last_word = (onum_ff == 3'd7);

   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnext = w_ff[0] + s0 + w_ff[9] + s1;
      e = v_ff[4];
      a = v_ff[0];
      kw = round_k(cnt_ff[5:0]) + w_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_ff[5]) ^ (~e & v_ff[6])) + kw;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      bitlen_in = bitlen_ff;
      final_in = final_ff;
      lenpass_in = lenpass_ff;
      marked_in = marked_ff;
      cnt_in = cnt_ff;
      h_in = h_ff;
      v_in = v_ff;
      w_in = w_ff;
      onum_in = onum_ff;
      ram_we = 1'b0;
      ram_wa = fill_ff[5:0];
      ram_wd = req_data_byte;
      ram_ra = cnt_ff[5:0];
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               if (req_byte_present) begin
                  ram_we = 1'b1;
                  bitlen_in = bitlen_ff + 64'd8;
               end
               fill_in = fill_ff + {6'd0, req_byte_present};
               final_in = req_final_item;
               lenpass_in = 1'b0;
               marked_in = 1'b0;
               cnt_in = '0;
               if (req_byte_present && fill_ff == 7'd63) begin
                  fill_in = '0;
                  state_in = ST_LOAD;
               end else if (req_final_item) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // First pad byte is 0x80, then zeros, then the length in bytes 56..63.
            ram_we = 1'b1;
            ram_wd = 8'h00;
            marked_in = 1'b1;
            if (cnt_ff == 7'd0) begin
               ram_wd = 8'h80;
               cnt_in = 7'd1;
            end
            if (fill_ff >= 7'd56 && lenpass_ff) begin
               ram_wd = bitlen_ff[8'd63 - {fill_ff[2:0], 3'd0} -: 8];
            end
            fill_in = fill_ff + 7'd1;
            if (fill_ff == 7'd63) begin
               fill_in = '0;
               cnt_in = '0;
               state_in = ST_LOAD;
            end else if (fill_ff == 7'd55 && !lenpass_ff && cnt_ff != 7'd0) begin
               lenpass_in = 1'b1;
            end else if (fill_ff == 7'd55 && !lenpass_ff) begin
               lenpass_in = 1'b1;
            end
         end
         ST_LOAD: begin
            // Shift bytes into the schedule window; the RAM read is registered, so nothing is shifted at count zero.
            if (cnt_ff != 7'd0) begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
               end
               w_in[15] = {w_ff[15][23:0], ram_rd};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               cnt_in = '0;
               v_in = h_ff;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = wnext;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            cnt_in = '0;
            onum_in = '0;
            if (!final_ff) begin
               state_in = ST_COLLECT;
            end else if (lenpass_ff) begin
               state_in = ST_EMIT;
            end else begin
               // The length is still to be written, and after a final 64th byte the 0x80 byte too.
               state_in = ST_PAD;
               cnt_in = {6'd0, marked_ff};
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               onum_in = onum_ff + 3'd1;
               if (onum_ff == 3'd7) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = init_hash(3'(i));
            end
            bitlen_in = '0;
            fill_in = '0;
            final_in = 1'b0;
            state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         fill_ff <= '0;
         bitlen_ff <= '0;
         final_ff <= 1'b0;
         lenpass_ff <= 1'b0;
         marked_ff <= 1'b0;
         cnt_ff <= '0;
         onum_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= init_hash(3'(i));
         end
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bitlen_ff <= bitlen_in;
         final_ff <= final_in;
         lenpass_ff <= lenpass_in;
         marked_ff <= marked_in;
         cnt_ff <= cnt_in;
         onum_ff <= onum_in;
         h_ff <= h_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   // Ready and valid are never high together: requests are taken only while collecting.
   a_ready_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and valid together");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid)
      else $error("output after last word");
   a_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && cnt_ff == 7'd63 |=> state_ff == ST_ADD)
      else $error("round count broken");
endmodule

/* tb/testbench.sv */
// Testbench for sha256_message_hasher: drives message bytes, predicts SHA-256 digests
// with its own compression routine and checks every digest word. Depends on the RTL only.
`timescale 1ns / 1ps
module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_final_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_number;
   logic        rsp_last_word;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } digest_entry_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // Predictor state.
   logic [31:0] hash_state [8];
   logic [7:0]  pending_block [64];
   int unsigned pending_fill;
   logic [63:0] message_bits;
   digest_entry_type expected_words[$];
   int unsigned mismatch_count = 0;
   bit          rsp_hold_off = 1'b0;

   sha256_message_hasher uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] rot_right(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_pending();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {pending_block[4*i], pending_block[4*i+1],
                 pending_block[4*i+2], pending_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3))
                + w[i-7] + (rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10));
      v = hash_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
         t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_state[i] += v[i];
   endtask

   task automatic restart_message();
      hash_state = InitHash;
      pending_fill = 0;
      message_bits = '0;
   endtask

   // Advances the predictor by one accepted word and queues any digest words.
   task automatic predict_digest(logic [7:0] data, logic present, logic last);
      digest_entry_type entry;
      if (present) begin
         pending_block[pending_fill] = data;
         pending_fill++;
         message_bits += 64'd8;
         if (pending_fill == 64) begin
            compress_pending();
            pending_fill = 0;
         end
      end
      if (last) begin
         pending_block[pending_fill] = 8'h80;
         pending_fill++;
         if (pending_fill > 56) begin
            while (pending_fill < 64) pending_block[pending_fill++] = 8'h00;
            compress_pending();
            pending_fill = 0;
         end
         while (pending_fill < 56) pending_block[pending_fill++] = 8'h00;
         for (int i = 0; i < 8; i++)
            pending_block[56+i] = message_bits[63-8*i -: 8];
         compress_pending();
         for (int i = 0; i < 8; i++) begin
            entry.digest_word = hash_state[i];
            entry.word_number = i[2:0];
            entry.last_word = (i == 7);
            expected_words.push_back(entry);
         end
         restart_message();
      end
   endtask

   function automatic int unsigned random_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Sends one word; the predictor runs when the word is accepted. Valid drops
   // only for a gap before the word, so back-to-back words keep it high.
   task automatic send_word(logic [7:0] data, logic present, logic last, bit allow_gap = 1);
      int unsigned gap;
      gap = allow_gap ? random_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_byte_present <= present;
      req_final_item <= last;
      do @(posedge clock); while (!req_ready);
      predict_digest(data, present, last);
   endtask

   task automatic send_message(int unsigned length, bit dense);
      for (int i = 0; i < length; i++) begin
         // Empty words inside a message must not change anything.
         if (!dense && $urandom_range(0, 9) == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, !dense);
      end
      if ($urandom_range(0, 1) == 0)
         send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, !dense);
      else
         send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, !dense);
   endtask

   task automatic test_empty_message();
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_byte_extremes();
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h5a, 1'b0, 1'b0);
      send_word(8'ha5, 1'b1, 1'b1);
   endtask

   // Lengths around the 55/56 byte padding boundary and full blocks.
   task automatic test_padding_boundaries();
      send_message(55, 1'b1);
      send_message(63, 1'b0);
   endtask

   task automatic test_random_messages();
      int unsigned length;
      for (int m = 0; m < 6; m++) begin
         length = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80)
                                              : $urandom_range(0, 20);
         send_message(length, $urandom_range(0, 3) == 0);
      end
   endtask

   always @(posedge clock) begin
      digest_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected digest word %h number %0d", rsp_digest_word,
                        rsp_word_number);
         end else begin
            want = expected_words.pop_front();
            if (rsp_digest_word !== want.digest_word || rsp_word_number !== want.word_number
                || rsp_last_word !== want.last_word) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           want.digest_word, want.word_number, want.last_word,
                           rsp_digest_word, rsp_word_number, rsp_last_word);
            end
         end
      end
   end

   // Random backpressure on the digest side, with calm stretches.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) rsp_hold_off <= ~rsp_hold_off;
      if (rsp_hold_off) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 29) == 0) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 2) != 0);
   end

   initial begin
      restart_message();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_byte_extremes();
      test_padding_boundaries();
      test_random_messages();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

/* sim.f */
rtl/core/sha256_pkg.sv
rtl/core/sha256_ram.sv
rtl/core/sha256_message_hasher.sv
tb/testbench.sv
